// ===== rtl/sorted_priority_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Concurrent check wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTH
`define SPQ_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SPQ_ASSERT(lbl, expr, msg)
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, operation and status codes, and the control word sent to every cell.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int RANK_W   = 16;
	localparam int OCC_W    = 5;
	localparam int STAT_W   = 2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

	typedef logic signed [VAL_W-1:0]  value_t;
	typedef logic signed [RANK_W-1:0] rank_t;

	typedef struct packed {
		logic   ins;
		logic   del;
		rank_t  rank;
		value_t value;
	} spq_ctrl_t;

endpackage

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One entry of the sorted chain: holds, takes the new word, or shifts.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
	input  logic      clk,
	input  spq_ctrl_t ctrl,
	input  logic      occupied,
	input  logic      prev_keep,
	input  rank_t     prev_rank,
	input  value_t    prev_value,
	input  rank_t     next_rank,
	input  value_t    next_value,
	output logic      keep,
	output rank_t     rank,
	output value_t    value
);

	rank_t  rank_q;
	value_t value_q;

	assign keep  = occupied && (rank_q <= ctrl.rank);
	assign rank  = rank_q;
	assign value = value_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && !keep) begin
			if (prev_keep) begin
				rank_q  <= ctrl.rank;
				value_q <= ctrl.value;
			end else begin
				rank_q  <= prev_rank;
				value_q <= prev_value;
			end
		end else if (ctrl.del) begin
			rank_q  <= next_rank;
			value_q <= next_value;
		end
	end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue of value/rank pairs kept sorted by rank in a chain of cells.
// ----------------------------------------------------------------------------
// Takes one insert or delete word per clock cycle while in_ready is high and
// returns its result word in the cycle after acceptance through an output
// register; input stays ready while that register is empty or being drained.
// Every cell compares its rank with the incoming rank at once, so an insert
// lands directly after all entries of lower or equal rank, and a delete shifts
// the whole chain one place toward the head. Entries are valid below the entry
// count; there is no clearing pass after reset. A full queue drops inserts
// with status full, an empty queue answers deletes with status underflow.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue import spq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                opcode,
	input  logic signed [31:0]  item_value,
	input  logic signed [15:0]  item_rank,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STAT_W-1:0]   status,
	output logic signed [31:0]  removed_value,
	output logic signed [15:0]  removed_rank,
	output logic [OCC_W-1:0]    occupancy
);

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nxt;
	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	value_t            rval_q;
	rank_t             rrank_q;
	logic [OCC_W-1:0]  occ_q;

	logic      acc;
	logic      is_full;
	logic      is_empty;
	spq_ctrl_t ctrl;
	logic [STAT_W-1:0] status_nxt;

	logic   keep_w  [CAPACITY];
	rank_t  rank_w  [CAPACITY];
	value_t value_w [CAPACITY];

	assign in_ready = !out_valid_q || out_ready;
	assign acc      = in_valid && in_ready;
	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	assign ctrl.ins   = acc && (opcode == OP_INSERT) && !is_full;
	assign ctrl.del   = acc && (opcode == OP_DELETE) && !is_empty;
	assign ctrl.rank  = item_rank;
	assign ctrl.value = item_value;

	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_OK;
		if (ctrl.ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctrl.del) begin
			count_nxt = count_q - CNT_W'(1);
		end
		if (opcode == OP_INSERT && is_full) begin
			status_nxt = ST_FULL;
		end else if (opcode == OP_DELETE && is_empty) begin
			status_nxt = ST_UNDERFLOW;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   prev_keep;
		rank_t  prev_rank;
		value_t prev_value;
		rank_t  next_rank;
		value_t next_value;

		if (i == 0) begin : g_head
			assign prev_keep  = 1'b1;
			assign prev_rank  = ctrl.rank;
			assign prev_value = ctrl.value;
		end else begin : g_body
			assign prev_keep  = keep_w[i-1];
			assign prev_rank  = rank_w[i-1];
			assign prev_value = value_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_rank  = rank_w[i];
			assign next_value = value_w[i];
		end else begin : g_mid
			assign next_rank  = rank_w[i+1];
			assign next_value = value_w[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (count_q > CNT_W'(i)),
			.prev_keep  (prev_keep),
			.prev_rank  (prev_rank),
			.prev_value (prev_value),
			.next_rank  (next_rank),
			.next_value (next_value),
			.keep       (keep_w[i]),
			.rank       (rank_w[i]),
			.value      (value_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q <= status_nxt;
			occ_q    <= OCC_W'(count_nxt);
			rval_q   <= ctrl.del ? value_w[0] : '0;
			rrank_q  <= ctrl.del ? rank_w[0] : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign removed_value = rval_q;
	assign removed_rank  = rrank_q;
	assign occupancy     = occ_q;

	`SPQ_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "entry count beyond capacity")
	`SPQ_ASSERT_NEXT(a_full_drop, acc && opcode == OP_INSERT && is_full, out_valid && status == ST_FULL && $stable(count_q), "insert into full queue not dropped")
	`SPQ_ASSERT_NEXT(a_underflow, acc && opcode == OP_DELETE && is_empty, out_valid && status == ST_UNDERFLOW && count_q == '0, "delete from empty queue not flagged")
	`SPQ_ASSERT_NEXT(a_ins_count, ctrl.ins, count_q == $past(count_q) + CNT_W'(1), "insert did not grow the queue")

endmodule
